// File: src/bpc_pkg.sv
// bpc_pkg: shared types and constants of the button press classifier
`timescale 1ns / 1ps

package bpc_pkg;

    // event codes carried on the result channel
    typedef logic [3:0] t_event;

    localparam t_event EV_NONE       = 4'd0;
    localparam t_event EV_OK_SHORT   = 4'd1;
    localparam t_event EV_OK_LONG    = 4'd2;
    localparam t_event EV_A_SHORT    = 4'd3;
    localparam t_event EV_B_SHORT    = 4'd4;
    localparam t_event EV_BOTH_SHORT = 4'd5;
    localparam t_event EV_A_LONG     = 4'd6;
    localparam t_event EV_B_LONG     = 4'd7;
    localparam t_event EV_BOTH_LONG  = 4'd8;

    // a/b pair pattern, bit 1 is a, bit 0 is b
    typedef logic [1:0] t_pair;

    localparam t_pair PAIR_NONE = 2'b00;
    localparam t_pair PAIR_B    = 2'b01;
    localparam t_pair PAIR_A    = 2'b10;
    localparam t_pair PAIR_BOTH = 2'b11;

    // threshold register
    localparam int THR_W = 16;
    typedef logic [THR_W-1:0] t_thr;
    localparam t_thr LONG_PRESS_RESET = 16'd400;

    typedef logic [31:0] t_time;

    // one button sample
    typedef struct packed {
        logic  key_a;
        logic  key_b;
        logic  key_ok;
        t_time now_ms;
    } t_sample;

    // remembered key levels and change times
    typedef struct packed {
        logic  ok_prev;
        t_time ok_time;
        t_pair pair_prev;
        t_time pair_time;
    } t_state;

endpackage

// File: src/bpc_in_if.sv
// bpc_in_if: button sample channel
`timescale 1ns / 1ps

interface bpc_in_if;
    logic        valid;
    logic        ready;
    logic        key_a;
    logic        key_b;
    logic        key_ok;
    logic [31:0] now_ms;

    modport source (output valid, output key_a, output key_b, output key_ok,
                    output now_ms, input ready);
    modport sink   (input valid, input key_a, input key_b, input key_ok,
                    input now_ms, output ready);
endinterface

// File: src/bpc_out_if.sv
// bpc_out_if: press event channel
`timescale 1ns / 1ps

interface bpc_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] event_res;
    logic       any_pressed;

    modport source (output valid, output event_res, output any_pressed, input ready);
    modport sink   (input valid, input event_res, input any_pressed, output ready);
endinterface

// File: src/bpc_classify.sv
// bpc_classify: event decision and next key state for one sample
`timescale 1ns / 1ps

module bpc_classify (
    input  bpc_pkg::t_sample i_sample,
    input  bpc_pkg::t_state  i_state,
    input  bpc_pkg::t_thr    i_thr,
    output bpc_pkg::t_event  o_event,
    output bpc_pkg::t_state  o_state
);
    import bpc_pkg::*;

    t_time ok_el;
    t_time pair_el;
    t_time thr_ext;
    t_pair pair;

    // elapsed times wrap modulo 2^32
    assign pair    = {i_sample.key_a, i_sample.key_b};
    assign ok_el   = i_sample.now_ms - i_state.ok_time;
    assign pair_el = i_sample.now_ms - i_state.pair_time;
    assign thr_ext = {{(32-THR_W){1'b0}}, i_thr};

    // ok change first, then ok held, then the a/b pair
    always_comb begin
        o_event = EV_NONE;
        o_state = i_state;
        priority if (i_sample.key_ok != i_state.ok_prev) begin
            if (ok_el < thr_ext) begin
                o_event = EV_OK_SHORT;
            end
            o_state.ok_prev = i_sample.key_ok;
            o_state.ok_time = i_sample.now_ms;
        end else if (i_sample.key_ok && (ok_el > thr_ext)) begin
            o_event = EV_OK_LONG;
        end else if (pair == i_state.pair_prev) begin
            // steady pair, long event once past the threshold
            if (pair_el > thr_ext) begin
                unique case (pair)
                    PAIR_B:    o_event = EV_B_LONG;
                    PAIR_A:    o_event = EV_A_LONG;
                    PAIR_BOTH: o_event = EV_BOTH_LONG;
                    default:   o_event = EV_NONE;
                endcase
            end
        end else begin
            // pair changed
            if (pair != PAIR_NONE) begin
                // partial release from both held stays both
                o_state.pair_prev = (i_state.pair_prev == PAIR_BOTH) ? PAIR_BOTH : pair;
            end else begin
                o_state.pair_prev = PAIR_NONE;
                if (pair_el < thr_ext) begin
                    unique case (i_state.pair_prev)
                        PAIR_B:  o_event = EV_B_SHORT;
                        PAIR_A:  o_event = EV_A_SHORT;
                        default: o_event = EV_BOTH_SHORT;
                    endcase
                end
            end
            o_state.pair_time = i_sample.now_ms;
        end
    end

endmodule

// File: src/button_press_classifier_unit.sv
// button_press_classifier_unit: top level of the short/long button press classifier
`timescale 1ns / 1ps

// channel  | dir | payload                              | transfer
// i_in     | in  | key_a, key_b, key_ok, now_ms[31:0]   | valid & ready
// o_out    | out | event_res[3:0], any_pressed          | valid & ready
// i_cfg_*  | in  | long_press_ms[15:0]                  | i_cfg_we
//
// one sample per cycle while the output does not stall; each sample passes the
// input register, then the result register, with the key state updated alongside
// synchronous active-low reset clears key state, valids and sets threshold to 400
// the input register refills whenever the result register drains or is empty,
// so a stall on the output holds at most two samples in flight

module button_press_classifier_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    bpc_in_if.sink              i_in,
    bpc_out_if.source           o_out,
    input  logic                i_cfg_we,
    input  bpc_pkg::t_thr       i_cfg_wdata
);
    import bpc_pkg::*;

    logic    r_in_valid;
    t_sample r_in;
    logic    r_out_valid;
    t_event  r_out_event;
    logic    r_out_any;
    t_state  r_state;
    t_thr    r_thr;

    t_event  n_event;
    t_state  n_state;
    logic    advance;

    // stage hand-off
    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= LONG_PRESS_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.key_a  <= i_in.key_a;
            r_in.key_b  <= i_in.key_b;
            r_in.key_ok <= i_in.key_ok;
            r_in.now_ms <= i_in.now_ms;
        end
    end

    // decision logic
    bpc_classify u_classify (
        .i_sample (r_in),
        .i_state  (r_state),
        .i_thr    (r_thr),
        .o_event  (n_event),
        .o_state  (n_state)
    );

    // key state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_event <= n_event;
            r_out_any   <= r_in.key_a | r_in.key_b | r_in.key_ok;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.event_res   = r_out_event;
    assign o_out.any_pressed = r_out_any;

    // checks

    // events stay within the defined codes
    a_event_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_event <= EV_BOTH_LONG))
        else $error("event code out of range");

    // a long ok event needs a pressed key
    a_ok_long_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_event == EV_OK_LONG)) |-> r_out_any)
        else $error("ok long without a pressed key");

    // key state only moves when a sample passes to the result register
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!advance && $past(i_rst_n)) |=> $stable(r_state))
        else $error("key state changed without a sample");

    // a partial release from both held keeps both
    a_both_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_state.pair_prev == PAIR_BOTH) && (r_in.key_a || r_in.key_b))
        |=> (r_state.pair_prev == PAIR_BOTH))
        else $error("both-held pair not kept on partial release");

endmodule
